/* design/pfr_pkg.sv */
// Shared constants, types and index maps for the polyphase FIR resampler kernel.
// Depends on nothing; every other file of the block imports it.
package pfr_pkg;

   localparam int TAPS        = 8;
   localparam int PHASES      = 64;
   localparam int FRAC_BITS   = 11;

   localparam int NUM_SAMPLES = 8;
   localparam int NUM_ROWS    = 2 * PHASES;
   localparam int ROW_W       = $clog2(NUM_ROWS);
   localparam int TAP_W       = (TAPS > 1) ? $clog2(TAPS) : 1;

   localparam int ROW_IN_W    = 7;
   localparam int TAP_IN_W    = 3;
   localparam int ROW_CODES   = 2 ** ROW_IN_W;
   localparam int TAP_CODES   = 2 ** TAP_IN_W;

   localparam int DATA_W      = 16;
   localparam int PROD_W      = 2 * DATA_W;
   localparam int SUM_W       = PROD_W + $clog2(TAPS);

   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_FILTER = 1'b1;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   typedef data_type sample_vec_type [NUM_SAMPLES];
   typedef data_type coef_vec_type   [TAPS];

   typedef logic [ROW_W-1:0] row_map_type [ROW_CODES];
   typedef logic [TAP_W-1:0] tap_map_type [TAP_CODES];

   typedef struct packed {
      logic ld_prod;
      logic ld_sum;
   } pipe_ctrl_type;

   // wrap the incoming row code onto the table depth
   function automatic row_map_type build_row_map();
      row_map_type m;
      for (int i = 0; i < ROW_CODES; i++) begin
         m[i] = ROW_W'(i % NUM_ROWS);
      end
      return m;
   endfunction

   // wrap the incoming tap code onto the tap count
   function automatic tap_map_type build_tap_map();
      tap_map_type m;
      for (int i = 0; i < TAP_CODES; i++) begin
         m[i] = TAP_W'(i % TAPS);
      end
      return m;
   endfunction

   localparam row_map_type ROW_MAP = build_row_map();
   localparam tap_map_type TAP_MAP = build_tap_map();

endpackage

/* design/pfr_if.sv */
// Valid/ready channel interfaces for request and response words.
// Depends on pfr_pkg for field widths.
interface pfr_req_if;
   import pfr_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    kind;
   logic [ROW_IN_W-1:0]     phase_row;
   logic [TAP_IN_W-1:0]     tap_index;
   logic signed [DATA_W-1:0] coef_value;
   logic signed [DATA_W-1:0] sample0;
   logic signed [DATA_W-1:0] sample1;
   logic signed [DATA_W-1:0] sample2;
   logic signed [DATA_W-1:0] sample3;
   logic signed [DATA_W-1:0] sample4;
   logic signed [DATA_W-1:0] sample5;
   logic signed [DATA_W-1:0] sample6;
   logic signed [DATA_W-1:0] sample7;

   modport source (
      output valid, kind, phase_row, tap_index, coef_value,
             sample0, sample1, sample2, sample3, sample4, sample5, sample6, sample7,
      input  ready
   );

   modport sink (
      input  valid, kind, phase_row, tap_index, coef_value,
             sample0, sample1, sample2, sample3, sample4, sample5, sample6, sample7,
      output ready
   );
endinterface

interface pfr_rsp_if;
   import pfr_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [DATA_W-1:0] pixel_out;

   modport source (output valid, pixel_out, input ready);
   modport sink   (input valid, pixel_out, output ready);
endinterface

/* design/pfr_coef_store.sv */
// Coefficient table: one memory per tap lane, a whole row read per cycle.
// Depends on pfr_pkg.
module pfr_coef_store (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [pfr_pkg::ROW_W-1:0] wr_row,
   input  logic [pfr_pkg::TAP_W-1:0] wr_tap,
   input  pfr_pkg::data_type         wr_data,
   input  logic                      rd_en,
   input  logic [pfr_pkg::ROW_W-1:0] rd_row,
   output pfr_pkg::coef_vec_type     rd_coef
);
   import pfr_pkg::*;

   coef_vec_type rd_ff;

   for (genvar t = 0; t < TAPS; t++) begin : g_lane
      data_type coef_mem [NUM_ROWS];

      always_ff @(posedge clock) begin
         if (wr_en && (wr_tap == TAP_W'(t))) begin
            coef_mem[wr_row] <= wr_data;
         end
         if (rd_en) begin
            rd_ff[t] <= coef_mem[rd_row];
         end
      end
   end

   assign rd_coef = rd_ff;

endmodule

/* design/pfr_dot_product.sv */
// Multiply stage and summing stage of the filter datapath.
// Depends on pfr_pkg.
module pfr_dot_product (
   input  logic                   clock,
   input  pfr_pkg::pipe_ctrl_type ctrl,
   input  pfr_pkg::sample_vec_type sample,
   input  pfr_pkg::coef_vec_type  coef,
   output pfr_pkg::data_type      pixel
);
   import pfr_pkg::*;

   prod_type prod_ff [TAPS];
   prod_type prod_in [TAPS];
   sum_type  sum_ff;
   sum_type  sum_in;

   // lanes past the sample fields see a zero sample
   for (genvar t = 0; t < TAPS; t++) begin : g_mul
      if (t < NUM_SAMPLES) begin : g_live
         assign prod_in[t] = PROD_W'(sample[t]) * PROD_W'(coef[t]);
      end else begin : g_zero
         assign prod_in[t] = '0;
      end

      always_ff @(posedge clock) begin
         if (ctrl.ld_prod) begin
            prod_ff[t] <= prod_in[t];
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int t = 0; t < TAPS; t++) begin
         sum_in = sum_in + SUM_W'(prod_ff[t]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld_sum) begin
         sum_ff <= sum_in;
      end
   end

   // keep the bits from the binary point up: arithmetic shift, then truncate
   assign pixel = sum_ff[FRAC_BITS +: DATA_W];

endmodule

/* design/polyphase_fir_resampler_kernel_core.sv */
// Top level of the polyphase FIR resampler kernel: handshake control and stage valids.
// Depends on pfr_pkg, pfr_if, pfr_coef_store and pfr_dot_product.
//
//   channel   direction  word carried
//   -------   ---------  ------------------------------------------------------
//   req_bus   in         kind, phase_row, tap_index, coef_value, sample0..sample7
//   rsp_bus   out        pixel_out, one per filter word
//
// One word is taken per cycle while req_bus.ready is high. A filter word goes through
// the row read, multiply and sum registers to rsp_bus. A coefficient word is
// written into the table at the edge it is taken and gives no response; a filter
// word taken in the next cycle already sees it. Reset clears only the stage
// valids; the table holds whatever it held until each entry is written. A stalled
// stage holds its word, and req_bus.ready drops only when all three stages are full.
module polyphase_fir_resampler_kernel_core (
   input  logic      clock,
   input  logic      reset,
   pfr_req_if.sink   req_bus,
   pfr_rsp_if.source rsp_bus
);
   import pfr_pkg::*;

   // stage valids: 1 row read, 2 products, 3 sum (response register)
   logic v1_ff, v1_in;
   logic v2_ff, v2_in;
   logic v3_ff, v3_in;

   logic rdy1, rdy2, rdy3;
   logic take;
   logic take_filter;
   logic take_write;

   logic [ROW_W-1:0] row_sel;
   logic [TAP_W-1:0] tap_sel;

   sample_vec_type sample_in;
   sample_vec_type sample_ff;
   coef_vec_type   coef_row;
   pipe_ctrl_type  ctrl;
   data_type       pixel;

   // a stage may load when it is empty or its word moves on
   assign rdy3 = !v3_ff || rsp_bus.ready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_bus.ready = rdy1;
   assign take          = req_bus.valid && rdy1;
   assign take_filter   = take && (req_bus.kind == KIND_FILTER);
   assign take_write    = take && (req_bus.kind == KIND_WRITE);

   // wrap out-of-range row and tap codes
   assign row_sel = ROW_MAP[req_bus.phase_row];
   assign tap_sel = TAP_MAP[req_bus.tap_index];

   assign sample_in[0] = req_bus.sample0;
   assign sample_in[1] = req_bus.sample1;
   assign sample_in[2] = req_bus.sample2;
   assign sample_in[3] = req_bus.sample3;
   assign sample_in[4] = req_bus.sample4;
   assign sample_in[5] = req_bus.sample5;
   assign sample_in[6] = req_bus.sample6;
   assign sample_in[7] = req_bus.sample7;

   always_comb begin
      v1_in = v1_ff;
      v2_in = v2_ff;
      v3_in = v3_ff;
      if (rdy1) begin
         v1_in = take_filter;
      end
      if (rdy2) begin
         v2_in = v1_ff;
      end
      if (rdy3) begin
         v3_in = v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // hold the samples alongside the row read
   always_ff @(posedge clock) begin
      if (take_filter) begin
         sample_ff <= sample_in;
      end
   end

   pfr_coef_store u_coef_store (
      .clock   (clock),
      .wr_en   (take_write),
      .wr_row  (row_sel),
      .wr_tap  (tap_sel),
      .wr_data (req_bus.coef_value),
      .rd_en   (take_filter),
      .rd_row  (row_sel),
      .rd_coef (coef_row)
   );

   // advance products and sum only when the next stage has room
   assign ctrl.ld_prod = rdy2 && v1_ff;
   assign ctrl.ld_sum  = rdy3 && v2_ff;

   pfr_dot_product u_dot_product (
      .clock  (clock),
      .ctrl   (ctrl),
      .sample (sample_ff),
      .coef   (coef_row),
      .pixel  (pixel)
   );

   assign rsp_bus.valid     = v3_ff;
   assign rsp_bus.pixel_out = pixel;

endmodule
